>>> sv/reed_solomon_parity_encoder_macros.svh
// assertion macros shared by the encoder modules
`ifndef REED_SOLOMON_PARITY_ENCODER_MACROS_SVH
`define REED_SOLOMON_PARITY_ENCODER_MACROS_SVH

`ifndef ASSERT_OFF

// property must hold at every clock edge outside reset
`define RSPE_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// condition must never be seen outside reset
`define RSPE_ASSERT_NEVER(lbl, clk, rst, cond, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);

`else

`define RSPE_ASSERT(lbl, clk, rst, prop, msg)
`define RSPE_ASSERT_NEVER(lbl, clk, rst, cond, msg)

`endif

`endif

>>> sv/rspe_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package rspe_pkg;

   typedef logic [7:0] byte_type;

   // low byte of the field polynomial x^8+x^4+x^3+x^2+1
   localparam byte_type FIELD_POLY_LO = 8'h1D;

   // parity count register
   localparam int ECC_WIDTH = 5;
   localparam logic [ECC_WIDTH-1:0] ECC_RESET = 5'd10;
   localparam int ECC_MIN = 2;

   // blocks held between front and back, a power of two
   localparam int QUEUE_DEPTH = 2;

   // multiply by alpha
   function automatic byte_type gf_xtime(input byte_type a);
      return {a[6:0], 1'b0} ^ (a[7] ? FIELD_POLY_LO : 8'h00);
   endfunction

   // shift-and-add product in GF(256)
   function automatic byte_type gf_mul(input byte_type a, input byte_type b);
      byte_type x;
      byte_type acc;
      x = a;
      acc = '0;
      for (int k = 0; k < 8; k++) begin
         if (b[k]) begin
            acc = acc ^ x;
         end
         x = gf_xtime(x);
      end
      return acc;
   endfunction

endpackage

`default_nettype wire

>>> sv/rspe_gen_builder.sv
`timescale 1ns / 1ps
`default_nettype none

`include "reed_solomon_parity_encoder_macros.svh"

module rspe_gen_builder #(
   parameter int MAX_PARITY = 30
) (
   input  wire logic                                   clock,
   input  wire logic                                   reset,
   input  wire logic                                   restart,
   input  wire logic [$clog2(MAX_PARITY+1)-1:0]        n_i,
   output rspe_pkg::byte_type [MAX_PARITY:0]           gen_o,
   output logic                                        gen_ready
);
   import rspe_pkg::*;

   localparam int NW = $clog2(MAX_PARITY + 1);

   byte_type [MAX_PARITY:0] gen_ff, gen_in;
   byte_type                root_ff, root_in;
   logic [NW-1:0]           step_ff, step_in;

   assign gen_ready = (step_ff == n_i);
   assign gen_o     = gen_ff;

   // one root factor (x + alpha^i) multiplied in per cycle
   always_comb begin
      gen_in  = gen_ff;
      root_in = root_ff;
      step_in = step_ff;
      if (restart) begin
         gen_in    = '0;
         gen_in[0] = 8'h01;
         root_in   = 8'h01;
         step_in   = '0;
      end else if (!gen_ready) begin
         for (int j = 1; j <= MAX_PARITY; j++) begin
            gen_in[j] = gen_ff[j] ^ gf_mul(gen_ff[j-1], root_ff);
         end
         root_in = gf_xtime(root_ff);
         step_in = step_ff + NW'(1);
      end
   end

   // reset starts a build for the reset parity count
   always_ff @(posedge clock) begin
      if (reset) begin
         gen_ff    <= '0;
         gen_ff[0] <= 8'h01;
         root_ff   <= 8'h01;
         step_ff   <= '0;
      end else begin
         gen_ff  <= gen_in;
         root_ff <= root_in;
         step_ff <= step_in;
      end
   end

   `RSPE_ASSERT_NEVER(a_step_bound, clock, reset, step_ff > n_i, "generator build overran")

endmodule

`default_nettype wire

>>> sv/rspe_front.sv
`timescale 1ns / 1ps
`default_nettype none

module rspe_front #(
   parameter int MAX_PARITY = 30
) (
   input  wire logic                                   clock,
   input  wire logic                                   reset,
   input  wire logic                                   req_valid,
   output logic                                        req_ready,
   input  wire rspe_pkg::byte_type                     req_data_byte,
   input  wire logic                                   req_last_data,
   input  wire logic                                   gen_ready,
   input  wire rspe_pkg::byte_type [MAX_PARITY:0]      gen_i,
   input  wire logic [$clog2(MAX_PARITY+1)-1:0]        n_i,
   input  wire logic                                   q_full,
   output logic                                        push,
   output rspe_pkg::byte_type [MAX_PARITY-1:0]         push_bytes,
   output logic [$clog2(MAX_PARITY+1)-1:0]             push_n
);
   import rspe_pkg::*;

   localparam int NW = $clog2(MAX_PARITY + 1);

   byte_type [MAX_PARITY-1:0] rem_ff, rem_in;
   byte_type [MAX_PARITY-1:0] rem_next;
   byte_type [MAX_PARITY-1:0] upper;
   byte_type                  fb;
   logic                      accept;

   assign req_ready = gen_ready && !q_full;
   assign accept    = req_valid && req_ready;
   assign fb        = req_data_byte ^ rem_ff[0];

   // neighbor one degree down, zero past the top lane
   for (genvar j = 0; j < MAX_PARITY; j++) begin : g_lane
      if (j < MAX_PARITY - 1) begin : g_mid
         assign upper[j] = rem_ff[j+1];
      end else begin : g_top
         assign upper[j] = '0;
      end
   end

   // division step: lanes above the active degree hold their value
   always_comb begin
      for (int j = 0; j < MAX_PARITY; j++) begin
         if (NW'(j + 1) < n_i) begin
            rem_next[j] = upper[j] ^ gf_mul(fb, gen_i[j+1]);
         end else if (NW'(j + 1) == n_i) begin
            rem_next[j] = gf_mul(fb, gen_i[j+1]);
         end else begin
            rem_next[j] = rem_ff[j];
         end
      end
   end

   // finished remainder goes to the queue and the register clears
   assign push       = accept && req_last_data;
   assign push_bytes = rem_next;
   assign push_n     = n_i;

   always_comb begin
      rem_in = rem_ff;
      if (accept) begin
         rem_in = req_last_data ? '0 : rem_next;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rem_ff <= '0;
      end else begin
         rem_ff <= rem_in;
      end
   end

endmodule

`default_nettype wire

>>> sv/rspe_queue.sv
`timescale 1ns / 1ps
`default_nettype none

`include "reed_solomon_parity_encoder_macros.svh"

module rspe_queue #(
   parameter int MAX_PARITY = 30
) (
   input  wire logic                                   clock,
   input  wire logic                                   reset,
   input  wire logic                                   push,
   input  wire rspe_pkg::byte_type [MAX_PARITY-1:0]    push_bytes,
   input  wire logic [$clog2(MAX_PARITY+1)-1:0]        push_n,
   output logic                                        full,
   output logic                                        head_valid,
   output rspe_pkg::byte_type [MAX_PARITY-1:0]         head_bytes,
   output logic [$clog2(MAX_PARITY+1)-1:0]             head_n,
   input  wire logic                                   pop
);
   import rspe_pkg::*;

   localparam int NW = $clog2(MAX_PARITY + 1);
   localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CW = $clog2(QUEUE_DEPTH + 1);

   byte_type [MAX_PARITY-1:0] ent_bytes_ff [QUEUE_DEPTH];
   logic [NW-1:0]             ent_n_ff     [QUEUE_DEPTH];
   logic [PW-1:0]             wptr_ff, wptr_in;
   logic [PW-1:0]             rptr_ff, rptr_in;
   logic [CW-1:0]             cnt_ff, cnt_in;

   assign full       = (cnt_ff == CW'(QUEUE_DEPTH));
   assign head_valid = (cnt_ff != '0);
   assign head_bytes = ent_bytes_ff[rptr_ff];
   assign head_n     = ent_n_ff[rptr_ff];

   // pointers wrap on their own since the depth is a power of two
   always_comb begin
      wptr_in = push ? wptr_ff + PW'(1) : wptr_ff;
      rptr_in = pop ? rptr_ff + PW'(1) : rptr_ff;
      cnt_in  = cnt_ff;
      if (push && !pop) begin
         cnt_in = cnt_ff + CW'(1);
      end else if (pop && !push) begin
         cnt_in = cnt_ff - CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff <= '0;
         rptr_ff <= '0;
         cnt_ff  <= '0;
      end else begin
         wptr_ff <= wptr_in;
         rptr_ff <= rptr_in;
         cnt_ff  <= cnt_in;
      end
   end

   // block storage
   always_ff @(posedge clock) begin
      if (push) begin
         ent_bytes_ff[wptr_ff] <= push_bytes;
         ent_n_ff[wptr_ff]     <= push_n;
      end
   end

   `RSPE_ASSERT(a_no_overflow, clock, reset, push |-> !full, "block pushed into a full queue")
   `RSPE_ASSERT(a_no_underflow, clock, reset, pop |-> head_valid, "block popped from an empty queue")

endmodule

`default_nettype wire

>>> sv/rspe_back.sv
`timescale 1ns / 1ps
`default_nettype none

`include "reed_solomon_parity_encoder_macros.svh"

module rspe_back #(
   parameter int MAX_PARITY = 30
) (
   input  wire logic                                   clock,
   input  wire logic                                   reset,
   input  wire logic                                   head_valid,
   input  wire rspe_pkg::byte_type [MAX_PARITY-1:0]    head_bytes,
   input  wire logic [$clog2(MAX_PARITY+1)-1:0]        head_n,
   output logic                                        pop,
   output logic                                        rsp_valid,
   input  wire logic                                   rsp_ready,
   output rspe_pkg::byte_type                          rsp_parity_byte,
   output logic                                        rsp_last_parity
);
   import rspe_pkg::*;

   localparam int NW = $clog2(MAX_PARITY + 1);

   byte_type [MAX_PARITY-1:0] sr_ff, sr_in;
   logic [NW-1:0]             cnt_ff, cnt_in;
   logic                      fire;

   assign rsp_valid       = (cnt_ff != '0);
   assign rsp_parity_byte = sr_ff[0];
   assign rsp_last_parity = (cnt_ff == NW'(1));
   assign fire            = rsp_valid && rsp_ready;

   // next block loads while no block is being sent, or as the last beat of the current one leaves
   assign pop = head_valid && (!rsp_valid || (rsp_last_parity && fire));

   always_comb begin
      sr_in  = sr_ff;
      cnt_in = cnt_ff;
      if (pop) begin
         sr_in  = head_bytes;
         cnt_in = head_n;
      end else if (fire) begin
         for (int j = 0; j < MAX_PARITY - 1; j++) begin
            sr_in[j] = sr_ff[j+1];
         end
         sr_in[MAX_PARITY-1] = '0;
         cnt_in = cnt_ff - NW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      sr_ff <= sr_in;
   end

   `RSPE_ASSERT(a_load_count, clock, reset, pop |=> (cnt_ff >= NW'(ECC_MIN)), "short parity block")

endmodule

`default_nettype wire

>>> sv/reed_solomon_parity_encoder.sv
// a closed block's parity is written into the queue and then loaded into the output shift register
// throughput: one data beat per cycle, stalling while the two-block queue is full or the
//   generator is being built; one parity beat per cycle while rsp_ready is high, blocks
//   back to back; after reset, and after each csr write, input stalls while the generator
//   polynomial for the saturated parity count is built one root factor per cycle
// reset (synchronous): ecc_count 10, remainder and queue cleared
`timescale 1ns / 1ps
`default_nettype none

module reed_solomon_parity_encoder #(
   parameter int MAX_PARITY = 30
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            req_valid,
   output logic                                 req_ready,
   input  wire rspe_pkg::byte_type              req_data_byte,
   input  wire logic                            req_last_data,
   output logic                                 rsp_valid,
   input  wire logic                            rsp_ready,
   output rspe_pkg::byte_type                   rsp_parity_byte,
   output logic                                 rsp_last_parity,
   input  wire logic                            csr_write_en,
   input  wire logic [rspe_pkg::ECC_WIDTH-1:0]  csr_write_data
);
   import rspe_pkg::*;

   localparam int NW = $clog2(MAX_PARITY + 1);
   localparam int CW = (NW > ECC_WIDTH) ? NW : ECC_WIDTH;

   logic [ECC_WIDTH-1:0]      ecc_ff, ecc_in;
   logic [CW-1:0]             ecc_wide;
   logic [NW-1:0]             n_eff;
   byte_type [MAX_PARITY:0]   gen;
   logic                      gen_ready;
   logic                      q_full;
   logic                      push;
   byte_type [MAX_PARITY-1:0] push_bytes;
   logic [NW-1:0]             push_n;
   logic                      head_valid;
   byte_type [MAX_PARITY-1:0] head_bytes;
   logic [NW-1:0]             head_n;
   logic                      pop;

   // parity count register
   assign ecc_in = csr_write_en ? csr_write_data : ecc_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         ecc_ff <= ECC_RESET;
      end else begin
         ecc_ff <= ecc_in;
      end
   end

   // saturate into the supported degree range
   assign ecc_wide = CW'(ecc_ff);

   always_comb begin
      if (ecc_wide < CW'(ECC_MIN)) begin
         n_eff = NW'(ECC_MIN);
      end else if (ecc_wide > CW'(MAX_PARITY)) begin
         n_eff = NW'(MAX_PARITY);
      end else begin
         n_eff = NW'(ecc_wide);
      end
   end

   rspe_gen_builder #(
      .MAX_PARITY (MAX_PARITY)
   ) u_gen (
      .clock     (clock),
      .reset     (reset),
      .restart   (csr_write_en),
      .n_i       (n_eff),
      .gen_o     (gen),
      .gen_ready (gen_ready)
   );

   rspe_front #(
      .MAX_PARITY (MAX_PARITY)
   ) u_front (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_data_byte (req_data_byte),
      .req_last_data (req_last_data),
      .gen_ready     (gen_ready),
      .gen_i         (gen),
      .n_i           (n_eff),
      .q_full        (q_full),
      .push          (push),
      .push_bytes    (push_bytes),
      .push_n        (push_n)
   );

   rspe_queue #(
      .MAX_PARITY (MAX_PARITY)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_bytes (push_bytes),
      .push_n     (push_n),
      .full       (q_full),
      .head_valid (head_valid),
      .head_bytes (head_bytes),
      .head_n     (head_n),
      .pop        (pop)
   );

   rspe_back #(
      .MAX_PARITY (MAX_PARITY)
   ) u_back (
      .clock           (clock),
      .reset           (reset),
      .head_valid      (head_valid),
      .head_bytes      (head_bytes),
      .head_n          (head_n),
      .pop             (pop),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_parity_byte (rsp_parity_byte),
      .rsp_last_parity (rsp_last_parity)
   );

endmodule

`default_nettype wire

>>> bench/reed_solomon_parity_encoder_test.sv
`timescale 1ns / 1ps

module reed_solomon_parity_encoder_test;
   import rspe_pkg::*;

   localparam int MAX_PARITY = 30;
   localparam int SCRIPT_ROWS = 22;
   localparam int RANDOM_BEATS = 294;
   localparam int IDLE_PCT = 20;
   localparam int HOLD_CYCLES = 300;
   localparam int SETTLE_CYCLES = 8;
   localparam int DRAIN_CYCLES = 20;
   localparam int CYCLE_LIMIT = 200000;
   localparam int CALM_PHASE = 3;
   localparam int PRESSURE_PHASE = 5;

   typedef enum logic {ROW_BEAT, ROW_CSR} row_kind_type;

   typedef struct {
      row_kind_type kind;
      byte_type     value;
      logic         is_last;
      logic         pinned;
      byte_type     want_first;
   } script_row_type;

   typedef struct {
      logic     pinned;
      byte_type want_first;
   } beat_note_type;

   typedef struct {
      byte_type parity;
      logic     is_last;
   } parity_beat_type;

   logic clock = 1'b0;
   logic reset;
   logic req_valid;
   logic req_ready;
   byte_type req_data_byte;
   logic req_last_data;
   logic rsp_valid;
   logic rsp_ready;
   byte_type rsp_parity_byte;
   logic rsp_last_parity;
   logic csr_write_en;
   logic [ECC_WIDTH-1:0] csr_write_data;

   // predictor state: division remainder and generator coefficients
   byte_type remainder [0:MAX_PARITY-1];
   byte_type gen_coef [0:MAX_PARITY];
   int gen_degree;

   parity_beat_type parity_due [$];
   beat_note_type beat_notes [$];

   int mistakes = 0;
   int beats_taken = 0;
   int blocks_closed = 0;
   int parity_seen = 0;
   int csr_writes = 0;
   int cycle_count = 0;
   logic calm = 1'b0;
   logic hold_wanted = 1'b0;
   logic hold_served = 1'b0;

   // directed blocks: zero data, single beats, zero feedback, saturating csr values
   script_row_type script [0:SCRIPT_ROWS-1] = '{
      '{ROW_BEAT, 8'h00, 1'b0, 1'b0, 8'h00},
      '{ROW_BEAT, 8'h00, 1'b1, 1'b1, 8'h00},
      '{ROW_CSR,  8'd2,  1'b0, 1'b0, 8'h00},
      '{ROW_BEAT, 8'h01, 1'b1, 1'b1, 8'h03},
      '{ROW_BEAT, 8'h01, 1'b0, 1'b0, 8'h00},
      '{ROW_BEAT, 8'h03, 1'b1, 1'b1, 8'h02},
      '{ROW_CSR,  8'd0,  1'b0, 1'b0, 8'h00},
      '{ROW_BEAT, 8'hFF, 1'b1, 1'b0, 8'h00},
      '{ROW_CSR,  8'd1,  1'b0, 1'b0, 8'h00},
      '{ROW_BEAT, 8'h55, 1'b0, 1'b0, 8'h00},
      '{ROW_BEAT, 8'hAA, 1'b1, 1'b0, 8'h00},
      '{ROW_CSR,  8'd31, 1'b0, 1'b0, 8'h00},
      '{ROW_BEAT, 8'hFF, 1'b0, 1'b0, 8'h00},
      '{ROW_BEAT, 8'h00, 1'b0, 1'b0, 8'h00},
      '{ROW_BEAT, 8'h7F, 1'b1, 1'b0, 8'h00},
      '{ROW_CSR,  8'd30, 1'b0, 1'b0, 8'h00},
      '{ROW_BEAT, 8'h00, 1'b1, 1'b1, 8'h00},
      '{ROW_CSR,  8'd17, 1'b0, 1'b0, 8'h00},
      '{ROW_BEAT, 8'h12, 1'b0, 1'b0, 8'h00},
      '{ROW_BEAT, 8'h34, 1'b0, 1'b0, 8'h00},
      '{ROW_BEAT, 8'h56, 1'b0, 1'b0, 8'h00},
      '{ROW_BEAT, 8'h78, 1'b1, 1'b0, 8'h00}
   };

   reed_solomon_parity_encoder #(
      .MAX_PARITY(MAX_PARITY)
   ) dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_data_byte(req_data_byte),
      .req_last_data(req_last_data),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_parity_byte(rsp_parity_byte),
      .rsp_last_parity(rsp_last_parity),
      .csr_write_en(csr_write_en),
      .csr_write_data(csr_write_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // field product, horner form from the top bit of b down
   function automatic byte_type gf_product(input byte_type a, input byte_type b);
      byte_type acc;
      acc = '0;
      for (int k = 7; k >= 0; k--) begin
         acc = {acc[6:0], 1'b0} ^ (acc[7] ? FIELD_POLY_LO : 8'h00);
         if (b[k]) begin
            acc = acc ^ a;
         end
      end
      return acc;
   endfunction

   // generator for the saturated parity count, roots alpha^0 upward
   function automatic void load_generator(input logic [ECC_WIDTH-1:0] raw);
      byte_type root;
      int n;
      n = raw;
      if (n < ECC_MIN) begin
         n = ECC_MIN;
      end
      if (n > MAX_PARITY) begin
         n = MAX_PARITY;
      end
      gen_degree = n;
      gen_coef = '{default: 8'h00};
      gen_coef[0] = 8'h01;
      root = 8'h01;
      for (int i = 0; i < n; i++) begin
         for (int j = i + 1; j > 0; j--) begin
            gen_coef[j] = gen_coef[j] ^ gf_product(gen_coef[j-1], root);
         end
         root = gf_product(root, 8'h02);
      end
   endfunction

   // one division step; a closing beat queues the whole parity block
   function automatic void absorb_data_byte(input byte_type d, input logic is_last);
      byte_type fb;
      parity_beat_type pb;
      fb = d ^ remainder[0];
      for (int j = 0; j + 1 < gen_degree; j++) begin
         remainder[j] = remainder[j+1] ^ gf_product(fb, gen_coef[j+1]);
      end
      remainder[gen_degree-1] = gf_product(fb, gen_coef[gen_degree]);
      if (is_last) begin
         for (int j = 0; j < gen_degree; j++) begin
            pb.parity = remainder[j];
            pb.is_last = (j + 1 == gen_degree);
            parity_due.push_back(pb);
         end
         remainder = '{default: 8'h00};
         blocks_closed++;
      end
   endfunction

   // predictor and checker, all sampled at the rising edge
   always @(posedge clock) begin : model
      parity_beat_type due;
      beat_note_type note;
      if (reset) begin
         remainder = '{default: 8'h00};
         load_generator(ECC_RESET);
      end else begin
         if (rsp_valid && rsp_ready) begin
            parity_seen++;
            if (parity_due.size() == 0) begin
               mistakes++;
               $display("%0t: parity beat %02h with nothing expected", $time, rsp_parity_byte);
            end else begin
               due = parity_due.pop_front();
               if (rsp_parity_byte !== due.parity) begin
                  mistakes++;
                  $display("%0t: parity_byte expected %02h actual %02h",
                           $time, due.parity, rsp_parity_byte);
               end
               if (rsp_last_parity !== due.is_last) begin
                  mistakes++;
                  $display("%0t: last_parity expected %0b actual %0b",
                           $time, due.is_last, rsp_last_parity);
               end
            end
         end
         if (csr_write_en) begin
            load_generator(csr_write_data);
         end
         if (req_valid && req_ready) begin
            beats_taken++;
            note = beat_notes.pop_front();
            absorb_data_byte(req_data_byte, req_last_data);
            // hand-typed first parity byte overrides the computed one
            if (note.pinned && req_last_data) begin
               parity_due[parity_due.size() - gen_degree].parity = note.want_first;
            end
         end
      end
   end

   // receiver: random stalls, one long hold-off on request
   initial begin
      rsp_ready = 1'b0;
      @(posedge clock);
      forever begin
         if (hold_wanted && !hold_served) begin
            hold_served = 1'b1;
            rsp_ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
         end else begin
            rsp_ready <= calm || ($urandom_range(99) >= IDLE_PCT);
            @(posedge clock);
         end
      end
   end

   // run limit
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("%0t: timeout after %0d cycles", $time, cycle_count);
         $display("** reed_solomon_parity_encoder: FAILED **");
         $finish;
      end
   end

   // offer one data beat and hold it until taken
   task automatic push_beat(input byte_type d, input logic is_last, input logic pinned,
                            input byte_type want_first);
      beat_note_type note;
      while (!calm && $urandom_range(99) < IDLE_PCT) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      note.pinned = pinned;
      note.want_first = want_first;
      beat_notes.push_back(note);
      req_valid <= 1'b1;
      req_data_byte <= d;
      req_last_data <= is_last;
      do @(posedge clock); while (!req_ready);
   endtask

   // csr write once the last beat is predicted and all parity has drained
   task automatic write_ecc(input logic [ECC_WIDTH-1:0] value);
      req_valid <= 1'b0;
      @(posedge clock);
      wait (parity_due.size() == 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
      csr_write_en <= 1'b1;
      csr_write_data <= value;
      csr_writes++;
      @(posedge clock);
      csr_write_en <= 1'b0;
   endtask

   // one block of random data
   task automatic push_block(input int len);
      for (int k = 0; k < len; k++) begin
         push_beat(byte_type'($urandom_range(255)), k == len - 1, 1'b0, 8'h00);
      end
   endtask

   initial begin : stimulus
      int sent;
      int phase;
      int len;
      logic [ECC_WIDTH-1:0] raw;
      reset = 1'b1;
      req_valid = 1'b0;
      req_data_byte = '0;
      req_last_data = 1'b0;
      csr_write_en = 1'b0;
      csr_write_data = '0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // directed table
      for (int i = 0; i < SCRIPT_ROWS; i++) begin
         if (script[i].kind == ROW_CSR) begin
            write_ecc(script[i].value[ECC_WIDTH-1:0]);
         end else begin
            push_beat(script[i].value, script[i].is_last, script[i].pinned,
                      script[i].want_first);
         end
      end

      // random phases, each under its own parity count
      sent = 0;
      phase = 0;
      while (sent < RANDOM_BEATS) begin
         phase++;
         case ($urandom_range(9))
            0: raw = ($urandom_range(2) == 0) ? 5'd31 : 5'($urandom_range(1));
            1: raw = ECC_WIDTH'(ECC_MIN);
            2: raw = ECC_WIDTH'(MAX_PARITY);
            default: raw = 5'($urandom_range(MAX_PARITY, ECC_MIN));
         endcase
         if (phase == PRESSURE_PHASE) begin
            raw = ECC_WIDTH'(MAX_PARITY);
         end
         write_ecc(raw);
         calm = (phase == CALM_PHASE);
         if (phase == PRESSURE_PHASE) begin
            // long receiver stall while short blocks keep coming
            hold_wanted = 1'b1;
            for (int b = 0; b < 8; b++) begin
               push_block(2);
               sent += 2;
            end
         end else begin
            for (int b = $urandom_range(6, 2); b > 0; b--) begin
               len = ($urandom_range(9) == 0) ? $urandom_range(40, 9) : $urandom_range(6, 1);
               push_block(len);
               sent += len;
            end
         end
         calm = 1'b0;
      end

      req_valid <= 1'b0;
      @(posedge clock);
      wait (parity_due.size() == 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
      $display("covered %0d data beats in %0d blocks, %0d parity beats checked",
               beats_taken, blocks_closed, parity_seen);
      $display("%0d csr writes incl. saturating counts, one long output stall", csr_writes);
      if (mistakes == 0) begin
         $display("** reed_solomon_parity_encoder: PASSED **");
      end else begin
         $display("** reed_solomon_parity_encoder: FAILED **");
      end
      $finish;
   end

endmodule
